/* hw/rtl/armil_pkg.sv */
`default_nettype none

package armil_pkg;

  // Port widths
  localparam int unsigned KindW     = 3;
  localparam int unsigned ItemW     = 50;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 8;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned AngleLimW = 15;

  // Register reset values
  localparam logic signed [15:0]    ThrottleLimitRst = 16'sd819;   // 0.05 in Q1.14
  localparam logic [AngleLimW-1:0]  RollLimitRst     = 15'd2000;   // 20 deg
  localparam logic [AngleLimW-1:0]  PitchLimitRst    = 15'd2000;
  localparam logic [15:0]           ArmDelayRst      = 16'd500;
  localparam logic [15:0]           CheckIntervalRst = 16'd50;

  // One input item as packed in tdata; throttle sits in the low bits.
  typedef struct packed {
    logic               switch_on;
    logic               imu_ok;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] throttle;
  } item_t;

  typedef struct packed {
    logic signed [15:0]    throttle_limit;
    logic [AngleLimW-1:0]  roll_limit;
    logic [AngleLimW-1:0]  pitch_limit;
    logic [15:0]           arm_delay;
    logic [15:0]           check_interval;
  } cfg_t;

  // Status from the condition evaluator to the state machine
  typedef struct packed {
    logic check_due;   // check interval has elapsed
    logic cond_new;    // freshly evaluated arming conditions
    logic delay_done;  // pending arm request is old enough
  } cond_t;

endpackage

`default_nettype wire

/* hw/rtl/armil_cond.sv */
`default_nettype none

module armil_cond (
  input  armil_pkg::cfg_t                   cfg_i,
  input  armil_pkg::item_t                  item_i,
  input  logic                              switch_state_i,
  input  logic [armil_pkg::TimeW-1:0]       now_ms_i,
  input  logic [armil_pkg::TimeW-1:0]       last_check_ms_i,
  input  logic [armil_pkg::TimeW-1:0]       request_ms_i,
  output armil_pkg::cond_t                  cond_o
);
  import armil_pkg::*;

  logic [16:0]      roll_ext, pitch_ext;
  logic [16:0]      roll_mag, pitch_mag;
  logic [TimeW-1:0] since_check, since_request;
  logic             thr_ok, roll_ok, pitch_ok;

  // |x| in 17 bits so that -32768 maps to 32768 and fails any limit
  assign roll_ext  = {item_i.roll[15], item_i.roll};
  assign pitch_ext = {item_i.pitch[15], item_i.pitch};
  assign roll_mag  = item_i.roll[15]  ? 17'(-roll_ext)  : roll_ext;
  assign pitch_mag = item_i.pitch[15] ? 17'(-pitch_ext) : pitch_ext;

  assign thr_ok   = $signed(item_i.throttle) <= $signed(cfg_i.throttle_limit);
  assign roll_ok  = roll_mag  <= {2'b00, cfg_i.roll_limit};
  assign pitch_ok = pitch_mag <= {2'b00, cfg_i.pitch_limit};

  // elapsed times wrap modulo 2^32
  assign since_check   = now_ms_i - last_check_ms_i;
  assign since_request = now_ms_i - request_ms_i;

  assign cond_o.check_due  = since_check >= {16'b0, cfg_i.check_interval};
  assign cond_o.delay_done = since_request >= {16'b0, cfg_i.arm_delay};
  assign cond_o.cond_new   = thr_ok & roll_ok & pitch_ok & item_i.imu_ok & ~switch_state_i;

endmodule

`default_nettype wire

/* hw/rtl/arming_interlock_fsm_unit.sv */
`default_nettype none

// Arming interlock for a motor controller. Each request on the slave stream is
// one event, selected by tuser: millisecond tick, sample update (throttle, roll,
// pitch, IMU ready), arm request, disarm request, safety-switch setting or force
// disarm; codes 6 and 7 are ignored but still answered. Every event yields
// exactly one result on the master stream: the mode after the event (disarmed,
// ready to arm, arming, armed, disarming), the last evaluated arming conditions,
// whether a request of kind arm/disarm/force was accepted, and the safety switch
// state. Conditions are only re-evaluated on a sample update once check_interval
// ms have elapsed since the previous evaluation; a stored arm request turns into
// armed after arm_delay ms if the conditions still hold. Time advances only on
// tick events (32-bit wrapping counter). Throughput is one event per clock while
// the master stream takes results. The input register takes a request; the
// combinational evaluation and state update then load the result register once
// it is free, and the result is offered from there on the master stream.
// The result register lets a new request enter while the previous result waits.
// Configuration registers are written through the cfg channel, which is always
// ready; write them only while no event is in flight. Indexes beyond the
// register list are ignored.

module arming_interlock_fsm_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave stream: events
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: throttle[15:0], roll[31:16], pitch[47:32], imu_ok[48],
  //        switch_on[49], zero fill[55:50]
  input  logic [armil_pkg::InDataW-1:0]     s_axis_tdata_i,
  // tuser: kind[2:0]
  input  logic [armil_pkg::KindW-1:0]       s_axis_tuser_i,
  // master stream: results
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: arm_state[2:0], conditions_ok[3], accepted[4], safety_on[5],
  //        zero fill[7:6]
  output logic [armil_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [armil_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [armil_pkg::CfgDataW-1:0]    cfg_data_i
);
  import armil_pkg::*;

  typedef enum logic [2:0] {
    ModeDisarmed  = 3'd0,
    ModeReady     = 3'd1,
    ModeArming    = 3'd2,
    ModeArmed     = 3'd3,
    ModeDisarming = 3'd4
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KindTick    = 3'd0,
    KindSample  = 3'd1,
    KindArm     = 3'd2,
    KindDisarm  = 3'd3,
    KindSwitch  = 3'd4,
    KindForce   = 3'd5
  } kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    CfgThrottleLimit = 3'd0,
    CfgRollLimit     = 3'd1,
    CfgPitchLimit    = 3'd2,
    CfgArmDelay      = 3'd3,
    CfgCheckInterval = 3'd4
  } cfg_idx_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.throttle_limit <= ThrottleLimitRst;
      cfg_q.roll_limit     <= RollLimitRst;
      cfg_q.pitch_limit    <= PitchLimitRst;
      cfg_q.arm_delay      <= ArmDelayRst;
      cfg_q.check_interval <= CheckIntervalRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgThrottleLimit: cfg_q.throttle_limit <= $signed(cfg_data_i);
        CfgRollLimit:     cfg_q.roll_limit     <= cfg_data_i[AngleLimW-1:0];
        CfgPitchLimit:    cfg_q.pitch_limit    <= cfg_data_i[AngleLimW-1:0];
        CfgArmDelay:      cfg_q.arm_delay      <= cfg_data_i;
        CfgCheckInterval: cfg_q.check_interval <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                 in_valid_q;
  logic [KindW-1:0]     in_kind_q;
  item_t                in_item_q;
  logic                 out_valid_q;
  logic                 advance;   // event in input reg moves to result reg
  logic                 in_take;

  assign advance         = ~out_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign in_take         = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= s_axis_tuser_i;
      in_item_q <= item_t'(s_axis_tdata_i[ItemW-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Interlock state
  // ---------------------------------------------------------------------------
  mode_e              mode_q, mode_d;
  logic               cond_met_q, cond_met_d;
  logic [TimeW-1:0]   now_ms_q, now_ms_d;
  logic [TimeW-1:0]   last_check_ms_q, last_check_ms_d;
  logic [TimeW-1:0]   request_ms_q, request_ms_d;
  logic               pending_q, pending_d;
  logic               switch_q, switch_d;
  logic               out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic               acc;
  logic               cond_cur;
  logic               fire;
  cond_t              cond;

  armil_cond u_cond (
    .cfg_i           (cfg_q),
    .item_i          (in_item_q),
    .switch_state_i  (switch_q),
    .now_ms_i        (now_ms_q),
    .last_check_ms_i (last_check_ms_q),
    .request_ms_i    (request_ms_q),
    .cond_o          (cond)
  );

  assign fire     = in_valid_q & advance;
  // condition value used by the sample update: fresh if the interval elapsed
  assign cond_cur = cond.check_due ? cond.cond_new : cond_met_q;

  always_comb begin
    mode_d          = mode_q;
    cond_met_d      = cond_met_q;
    now_ms_d        = now_ms_q;
    last_check_ms_d = last_check_ms_q;
    request_ms_d    = request_ms_q;
    pending_d       = pending_q;
    switch_d        = switch_q;
    acc             = 1'b0;

    if (fire) begin
      unique case (in_kind_q)
        KindTick: begin
          now_ms_d = now_ms_q + 32'd1;
        end
        KindSample: begin
          if (cond.check_due) begin
            cond_met_d      = cond.cond_new;
            last_check_ms_d = now_ms_q;
          end
          unique case (mode_q)
            ModeDisarmed: begin
              if (cond_cur) mode_d = ModeReady;
            end
            ModeReady: begin
              if (!cond_cur) mode_d = ModeDisarmed;
            end
            ModeArming: begin
              if (!cond_cur) begin
                mode_d    = ModeDisarmed;
                pending_d = 1'b0;
              end else if (pending_q && cond.delay_done) begin
                mode_d = ModeArmed;
              end
            end
            ModeArmed: begin
              if (!cond_cur) mode_d = ModeDisarming;
            end
            default: begin
              // disarming completes on the next sample
              mode_d    = ModeDisarmed;
              pending_d = 1'b0;
            end
          endcase
        end
        KindArm: begin
          if (mode_q == ModeReady) begin
            request_ms_d = now_ms_q;
            pending_d    = 1'b1;
            mode_d       = ModeArming;
            acc          = 1'b1;
          end else if (mode_q == ModeArmed) begin
            acc = 1'b1;
          end
        end
        KindDisarm: begin
          if (mode_q != ModeDisarmed) begin
            mode_d    = ModeDisarming;
            pending_d = 1'b0;
            acc       = 1'b1;
          end
        end
        KindSwitch: begin
          switch_d = in_item_q.switch_on;
          if (in_item_q.switch_on && mode_q != ModeDisarmed) mode_d = ModeDisarming;
        end
        KindForce: begin
          mode_d    = ModeDisarming;
          pending_d = 1'b0;
          acc       = 1'b1;
        end
        default: ;  // unused kinds report state only
      endcase
    end

    out_valid_d = advance ? in_valid_q : out_valid_q;
    out_data_d  = fire ? {2'b00, switch_d, acc, cond_met_d, mode_d} : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= ModeDisarmed;
      cond_met_q      <= 1'b0;
      now_ms_q        <= '0;
      last_check_ms_q <= '0;
      request_ms_q    <= '0;
      pending_q       <= 1'b0;
      switch_q        <= 1'b0;
      out_valid_q     <= 1'b0;
      out_data_q      <= '0;
    end else begin
      mode_q          <= mode_d;
      cond_met_q      <= cond_met_d;
      now_ms_q        <= now_ms_d;
      last_check_ms_q <= last_check_ms_d;
      request_ms_q    <= request_ms_d;
      pending_q       <= pending_d;
      switch_q        <= switch_d;
      out_valid_q     <= out_valid_d;
      out_data_q      <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a stored arm request only lives in arming, armed or disarming
  a_pending_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (mode_q != ModeDisarmed && mode_q != ModeReady))
    else $error("arm request pending in disarmed/ready mode");

  // armed is entered only from arming
  a_armed_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeArmed && $past(mode_q) != ModeArmed) |-> $past(mode_q) == ModeArming)
    else $error("armed entered without arming");

  // the millisecond clock only steps by one
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (now_ms_q != $past(now_ms_q)) |-> now_ms_q == $past(now_ms_q) + 32'd1)
    else $error("millisecond clock jumped");

  // an accepted request never leaves the machine disarmed or ready
  a_acc_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[4]) |->
      (out_data_q[2:0] != ModeDisarmed && out_data_q[2:0] != ModeReady))
    else $error("accepted request with disarmed/ready result");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

// Arming interlock testbench.
// Events go in on the slave stream, one status result per event comes back on
// the master stream. A local copy of the interlock (mode, clock, last check
// time, pending arm request, safety switch, limits) predicts every status at
// the moment its request is accepted; the result checker pops and compares.
// Tests: directed corner events, register extremes, then long random flights
// built from well-formed arm/disarm sequences with some noise in between.

module tb_top;

  import armil_pkg::*;

  // ---------------------------------------------------------------------------
  // Codes
  // ---------------------------------------------------------------------------
  typedef enum logic [2:0] {
    EV_TICK    = 3'd0,
    EV_SAMPLE  = 3'd1,
    EV_ARM     = 3'd2,
    EV_DISARM  = 3'd3,
    EV_SWITCH  = 3'd4,
    EV_FORCE   = 3'd5,
    EV_RSVD6   = 3'd6,
    EV_RSVD7   = 3'd7
  } event_e;

  typedef enum logic [2:0] {
    MODE_DISARMED  = 3'd0,
    MODE_READY     = 3'd1,
    MODE_ARMING    = 3'd2,
    MODE_ARMED     = 3'd3,
    MODE_DISARMING = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_THR_LIMIT   = 3'd0,
    REG_ROLL_LIMIT  = 3'd1,
    REG_PITCH_LIMIT = 3'd2,
    REG_ARM_DELAY   = 3'd3,
    REG_CHECK_IVL   = 3'd4
  } reg_e;

  // Result tdata, arm_state in the low bits
  typedef struct packed {
    logic [1:0] fill;
    logic       safety_on;
    logic       accepted;
    logic       conditions_ok;
    logic [2:0] arm_state;
  } status_t;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          SETTLE_CYCLES = 8;      // settle time after the last status is back
  localparam int          RANDOM_EVENTS = 800;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InDataW-1:0]   s_axis_tdata_i  = '0;
  logic [KindW-1:0]     s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i      = '0;
  logic [CfgDataW-1:0]  cfg_data_i      = '0;

  arming_interlock_fsm_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Interlock predictor state (mirrors the block after reset)
  // ---------------------------------------------------------------------------
  mode_e              p_mode         = MODE_DISARMED;
  bit                 p_cond_ok      = 1'b0;
  bit [TimeW-1:0]     p_clock_ms     = '0;
  bit [TimeW-1:0]     p_eval_ms      = '0;
  bit [TimeW-1:0]     p_arm_req_ms   = '0;
  bit                 p_arm_req_live = 1'b0;
  bit                 p_safety       = 1'b0;

  logic signed [15:0]    p_thr_lim   = ThrottleLimitRst;
  logic [AngleLimW-1:0]  p_roll_lim  = RollLimitRst;
  logic [AngleLimW-1:0]  p_pitch_lim = PitchLimitRst;
  logic [15:0]           p_arm_wait  = ArmDelayRst;
  logic [15:0]           p_eval_gap  = CheckIntervalRst;

  status_t status_q[$];   // predicted statuses, oldest first
  int      err_cnt  = 0;
  int      n_events = 0;  // accepted events, ignored kinds not counted
  bit      calm     = 1'b0; // no idling on either side while set

  // Apply one event to the predictor, return the status it should produce.
  function automatic status_t next_status(event_e kind, item_t d);
    status_t            s;
    bit                 acc;
    logic signed [16:0] roll_mag;
    logic signed [16:0] pitch_mag;
    acc = 1'b0;
    case (kind)
      EV_TICK: begin
        p_clock_ms = p_clock_ms + 1;
      end
      EV_SAMPLE: begin
        // conditions only refreshed once the check interval has run out
        if (p_clock_ms - p_eval_ms >= p_eval_gap) begin
          roll_mag  = 17'(d.roll);
          pitch_mag = 17'(d.pitch);
          if (roll_mag < 0) roll_mag = -roll_mag;     // -32768 becomes 32768
          if (pitch_mag < 0) pitch_mag = -pitch_mag;
          p_cond_ok = (d.throttle <= p_thr_lim) &&
                      (roll_mag <= $signed({2'b00, p_roll_lim})) &&
                      (pitch_mag <= $signed({2'b00, p_pitch_lim})) &&
                      d.imu_ok && !p_safety;
          p_eval_ms = p_clock_ms;
        end
        case (p_mode)
          MODE_DISARMED: if (p_cond_ok) p_mode = MODE_READY;
          MODE_READY:    if (!p_cond_ok) p_mode = MODE_DISARMED;
          MODE_ARMING: begin
            if (!p_cond_ok) begin
              p_mode         = MODE_DISARMED;
              p_arm_req_live = 1'b0;
            end else if (p_arm_req_live && (p_clock_ms - p_arm_req_ms >= p_arm_wait)) begin
              p_mode = MODE_ARMED;
            end
          end
          MODE_ARMED:    if (!p_cond_ok) p_mode = MODE_DISARMING;
          default: begin
            // disarming completes on the next sample
            p_mode         = MODE_DISARMED;
            p_arm_req_live = 1'b0;
          end
        endcase
      end
      EV_ARM: begin
        if (p_mode == MODE_READY) begin
          p_arm_req_ms   = p_clock_ms;
          p_arm_req_live = 1'b1;
          p_mode         = MODE_ARMING;
          acc            = 1'b1;
        end else if (p_mode == MODE_ARMED) begin
          acc = 1'b1;
        end
      end
      EV_DISARM: begin
        if (p_mode != MODE_DISARMED) begin
          p_mode         = MODE_DISARMING;
          p_arm_req_live = 1'b0;
          acc            = 1'b1;
        end
      end
      EV_SWITCH: begin
        p_safety = d.switch_on;
        if (p_safety && p_mode != MODE_DISARMED) p_mode = MODE_DISARMING;
      end
      EV_FORCE: begin
        p_mode         = MODE_DISARMING;
        p_arm_req_live = 1'b0;
        acc            = 1'b1;
      end
      default: ;  // unused kinds: status only
    endcase
    s.fill          = '0;
    s.arm_state     = p_mode;
    s.conditions_ok = p_cond_ok;
    s.accepted      = acc;
    s.safety_on     = p_safety;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Pacing: mostly no gap, some short ones, a few long
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  // sink side: tready drops for random stretches
  int sink_wait = 0;
  always @(posedge clk_i) begin
    if (sink_wait == 0) sink_wait = idle_len();
    if (sink_wait != 0) begin
      sink_wait--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(string msg);
    err_cnt++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : status_check
    status_t got;
    status_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (status_q.size() == 0) begin
        log_mismatch($sformatf("status %02h with no request outstanding", got));
      end else begin
        want = status_q.pop_front();
        if (got.arm_state !== want.arm_state || got.conditions_ok !== want.conditions_ok ||
            got.accepted !== want.accepted || got.safety_on !== want.safety_on) begin
          log_mismatch($sformatf(
            "state %0d/%0d cond %b/%b acc %b/%b safety %b/%b (got/want)",
            got.arm_state, want.arm_state, got.conditions_ok, want.conditions_ok,
            got.accepted, want.accepted, got.safety_on, want.safety_on));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Valid stays high after acceptance; the next call either loads the next
  // request in the same step or drops valid for a gap.
  task automatic send_event(event_e kind, item_t d);
    int gap;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InDataW'(d);
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    status_q.push_back(next_status(kind, d));
    if (kind <= EV_FORCE) n_events++;
  endtask

  // Hold off the sender until every status is back, then let the pipe settle.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all five limit registers, only with the block idle.
  task automatic load_limits(logic signed [15:0] thr, logic [AngleLimW-1:0] rl,
                             logic [AngleLimW-1:0] pl, logic [15:0] dly,
                             logic [15:0] ivl);
    logic [15:0] vals [5];
    reg_e        idx;
    vals = '{thr, {1'b0, rl}, {1'b0, pl}, dly, ivl};
    drain_results();
    for (int i = 0; i < 5; i++) begin
      idx = reg_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= idx;
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        REG_THR_LIMIT:   p_thr_lim   = vals[i];
        REG_ROLL_LIMIT:  p_roll_lim  = vals[i][AngleLimW-1:0];
        REG_PITCH_LIMIT: p_pitch_lim = vals[i][AngleLimW-1:0];
        REG_ARM_DELAY:   p_arm_wait  = vals[i];
        REG_CHECK_IVL:   p_eval_gap  = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic item_t mk_sample(logic signed [15:0] thr, logic signed [15:0] rl,
                                      logic signed [15:0] pt, logic imu);
    item_t d;
    d.throttle  = thr;
    d.roll      = rl;
    d.pitch     = pt;
    d.imu_ok    = imu;
    d.switch_on = 1'b0;
    return d;
  endfunction

  // any bit pattern; angles mostly within +/-180 deg
  function automatic item_t noise_item();
    item_t d;
    d.throttle  = 16'($urandom);
    d.roll      = ($urandom_range(3) == 0) ? 16'($urandom)
                                           : 16'(int'($urandom_range(36000)) - 18000);
    d.pitch     = ($urandom_range(3) == 0) ? 16'($urandom)
                                           : 16'(int'($urandom_range(36000)) - 18000);
    d.imu_ok    = 1'($urandom_range(1));
    d.switch_on = 1'($urandom_range(1));
    return d;
  endfunction

  // sample that meets every limit, often right on a limit
  function automatic item_t good_sample();
    item_t d;
    int    span;
    int    lim;
    span       = int'(p_thr_lim) + 32768;
    d.throttle = 16'(($urandom_range(3) == 0) ? int'(p_thr_lim)
                                              : int'($urandom_range(span)) - 32768);
    lim        = int'(p_roll_lim);
    d.roll     = 16'(($urandom_range(3) == 0) ? ($urandom_range(1) ? lim : -lim)
                                              : int'($urandom_range(2 * lim)) - lim);
    lim        = int'(p_pitch_lim);
    d.pitch    = 16'(($urandom_range(3) == 0) ? ($urandom_range(1) ? lim : -lim)
                                              : int'($urandom_range(2 * lim)) - lim);
    d.imu_ok    = 1'b1;
    d.switch_on = 1'($urandom_range(1));
    return d;
  endfunction

  // sample that breaks exactly one condition
  function automatic item_t bad_sample();
    item_t d;
    int    pick;
    int    lim;
    int    over;
    d    = good_sample();
    pick = $urandom_range(3);
    case (pick)
      0: begin
        if (p_thr_lim != 16'sh7fff)
          d.throttle = 16'(int'(p_thr_lim) + 1 + int'($urandom_range(32766 - int'(p_thr_lim))));
        else
          d.imu_ok = 1'b0;
      end
      1, 2: begin
        lim  = (pick == 1) ? int'(p_roll_lim) : int'(p_pitch_lim);
        // full-scale negative angle fails even the widest limit
        over = (lim < 18000 && $urandom_range(7) != 0) ?
               lim + 1 + int'($urandom_range(17999 - lim)) : 32768;
        if ($urandom_range(1)) over = -over;
        if (pick == 1) d.roll = 16'(over);
        else d.pitch = 16'(over);
      end
      default: d.imu_ok = 1'b0;
    endcase
    return d;
  endfunction

  task automatic tick_burst(int most);
    repeat ($urandom_range(most)) send_event(EV_TICK, noise_item());
  endtask

  // One arming cycle: get to ready, request arm, wait out the delay,
  // hold armed a while, mostly leave by one of the disarm paths.
  task automatic fly_sequence();
    int tries;
    int gap_most;
    gap_most = (p_eval_gap > 59) ? 60 : int'(p_eval_gap) + 1;
    if (p_safety) send_event(EV_SWITCH, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));
    if (p_mode != MODE_DISARMED && p_mode != MODE_READY) begin
      if ($urandom_range(1)) send_event(EV_DISARM, noise_item());
      else send_event(EV_FORCE, noise_item());
    end
    tries = 0;
    while (p_mode != MODE_READY && tries < 4) begin
      tick_burst(gap_most);
      send_event(EV_SAMPLE, good_sample());
      tries++;
    end
    if ($urandom_range(19) == 0) send_event(event_e'($urandom_range(7)), noise_item());
    send_event(EV_ARM, noise_item());
    tries = 0;
    while (p_mode == MODE_ARMING && tries < 12) begin
      tick_burst((p_arm_wait > 8) ? 8 : int'(p_arm_wait));
      if ($urandom_range(24) == 0) send_event(EV_SAMPLE, bad_sample());
      else send_event(EV_SAMPLE, good_sample());
      tries++;
    end
    repeat ($urandom_range(4)) begin
      case ($urandom_range(2))
        0: send_event(EV_TICK, noise_item());
        1: send_event(EV_SAMPLE, good_sample());
        default: send_event(EV_ARM, noise_item());
      endcase
    end
    case ($urandom_range(4))
      0: send_event(EV_DISARM, noise_item());
      1: send_event(EV_FORCE, noise_item());
      2: send_event(EV_SWITCH, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b0) | item_t'(1) << 49);
      3: begin
        tick_burst(gap_most);
        send_event(EV_SAMPLE, bad_sample());
      end
      default: ;
    endcase
    if ($urandom_range(1)) send_event(EV_SAMPLE, good_sample());
  endtask

  // Mostly well-formed sequences, some raw noise, an occasional full drain.
  task automatic run_mix(int n_more);
    int stop_at;
    stop_at = n_events + n_more;
    while (n_events < stop_at) begin
      if ($urandom_range(49) == 0) drain_results();
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(4, 1)) send_event(event_e'($urandom_range(7)), noise_item());
      end else begin
        fly_sequence();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_events();
    // reset limits: no time has passed, so the first sample is not evaluated
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));
    send_event(EV_ARM, noise_item());      // refused from disarmed
    send_event(EV_DISARM, noise_item());   // refused from disarmed
    send_event(EV_RSVD6, noise_item());
    send_event(EV_RSVD7, noise_item());

    load_limits(ThrottleLimitRst, RollLimitRst, PitchLimitRst, 16'd2, 16'd0);
    // every value right on its limit passes
    send_event(EV_SAMPLE, mk_sample(ThrottleLimitRst, 16'sd2000, -16'sd2000, 1'b1));
    send_event(EV_ARM, noise_item());
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));   // delay not over
    send_event(EV_TICK, noise_item());
    send_event(EV_TICK, noise_item());
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));   // armed
    send_event(EV_ARM, noise_item());                                 // accepted, no effect
    send_event(EV_SAMPLE, mk_sample(16'sd820, 16'sd0, 16'sd0, 1'b1)); // throttle high
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));   // disarming done
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));   // ready
    send_event(EV_SWITCH, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b0) | item_t'(1) << 49);
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));   // switch blocks
    send_event(EV_SWITCH, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b0));
    // full-scale negative angles fail; lowest throttle passes
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sh8000, 16'sd0, 1'b1));
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sh8000, 1'b1));
    send_event(EV_SAMPLE, mk_sample(16'sh8000, 16'sd18000, -16'sd18000, 1'b1));
    send_event(EV_SAMPLE, mk_sample(16'sh8000, 16'sd0, 16'sd0, 1'b1));
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b0));   // IMU not ready
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd0, 16'sd0, 1'b1));
    send_event(EV_ARM, noise_item());
    send_event(EV_SAMPLE, mk_sample(16'sd0, 16'sd2001, 16'sd0, 1'b1)); // cancels arming
    send_event(EV_FORCE, noise_item());                                // from disarmed
    send_event(EV_DISARM, noise_item());                               // from disarming
    send_event(EV_SAMPLE, mk_sample(16'sh7fff, -16'sd18000, 16'sd18000, 1'b1));
  endtask

  task automatic test_register_extremes();
    load_limits(16'sh8000, '0, '0, 16'd0, 16'd0);
    run_mix(50);
    load_limits(16'sh7fff, 15'd18000, 15'd18000, 16'hffff, 16'hffff);
    run_mix(40);
    load_limits(16'sh7fff, 15'd18000, 15'd18000, 16'd0, 16'd0);
    run_mix(50);
    // reset values: checks only every 50 ticks, arming too slow to finish
    load_limits(ThrottleLimitRst, RollLimitRst, PitchLimitRst, ArmDelayRst,
                CheckIntervalRst);
    run_mix(150);
    load_limits(16'($urandom), 15'($urandom_range(18000)), 15'($urandom_range(18000)),
                16'($urandom_range(8)), 16'($urandom_range(4)));
    run_mix(50);
  endtask

  task automatic test_random_flights();
    int stop_at;
    stop_at = n_events + RANDOM_EVENTS;
    while (n_events < stop_at) begin
      load_limits(16'(int'($urandom_range(20000)) - 2000), 15'($urandom_range(18000)),
                  15'($urandom_range(18000)), 16'($urandom_range(6)),
                  16'($urandom_range(3)));
      calm = ($urandom_range(3) == 0);
      run_mix(200);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_events();
    test_register_extremes();
    test_random_flights();
    drain_results();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
